[design/sdlp_pkg.sv]
// Shared types and constants for the signed decimal pair line parser.
// Has no dependencies; every other design file uses it.
package sdlp_pkg;

  localparam int BYTE_W         = 8;
  localparam int VAL_W          = 32;
  localparam int LINE_BYTES_DEF = 128;

  // One finished line: the ok flag and the held coordinates.
  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } res_t;

endpackage

[design/sdlp_scan.sv]
// Per-byte parse step: phase machine, digit accumulator and held coordinates.
// Depends on sdlp_pkg.
module sdlp_scan #(
  parameter int LINE_BYTES = sdlp_pkg::LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  logic [sdlp_pkg::BYTE_W-1:0]    byte_in,
  output logic                           line_end,
  output sdlp_pkg::res_t                 res
);

  localparam int CNT_W = $clog2(LINE_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_BYTES - 1);
  localparam int PROD_W = sdlp_pkg::VAL_W + 4;

  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_NUL   = 8'd0;
  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_NL    = 8'd10;
  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_COMMA = 8'd44;
  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_MINUS = 8'd45;
  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_D0    = 8'd48;
  localparam logic [sdlp_pkg::BYTE_W-1:0] CH_D9    = 8'd57;

  localparam logic [sdlp_pkg::VAL_W-1:0] MAG_CAP = 32'h8000_0000;
  localparam logic [sdlp_pkg::VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    PH_WS1, PH_SGN1, PH_DIG1, PH_WS2, PH_SGN2, PH_DIG2, PH_DONE, PH_FAIL
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [sdlp_pkg::VAL_W-1:0]     mag_r, mag_nxt;
  logic                           neg_r, neg_nxt;
  logic [sdlp_pkg::VAL_W-1:0]     first_r, first_nxt;
  logic [sdlp_pkg::VAL_W-1:0]     held_y_r, held_y_nxt;
  logic [sdlp_pkg::VAL_W-1:0]     held_x_r, held_x_nxt;

  logic                           is_space, is_digit, is_sign, ok;
  logic [PROD_W-1:0]              prod;
  logic [sdlp_pkg::VAL_W-1:0]     mag_add, cur_val;

  assign line_end = (byte_in == CH_NL);
  assign is_space = (byte_in == CH_SPACE) || (byte_in >= CH_TAB && byte_in <= CH_CR);
  assign is_digit = (byte_in >= CH_D0) && (byte_in <= CH_D9);
  assign is_sign  = (byte_in == CH_PLUS) || (byte_in == CH_MINUS);
  assign ok       = (phase_r == PH_DIG2) || (phase_r == PH_DONE);

  // Magnitude times ten plus the digit, clamped at 2^31.
  always_comb begin
    prod = (PROD_W'(mag_r) << 3) + (PROD_W'(mag_r) << 1)
         + PROD_W'(byte_in - CH_D0);
    mag_add = (prod > PROD_W'(MAG_CAP)) ? MAG_CAP : prod[sdlp_pkg::VAL_W-1:0];
  end

  // Saturated two's complement value; a negative 2^31 is its own negation.
  always_comb begin
    if (neg_r) begin
      cur_val = '0 - mag_r;
    end else begin
      cur_val = (mag_r >= MAG_CAP) ? POS_MAX : mag_r;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    first_nxt  = first_r;
    held_y_nxt = held_y_r;
    held_x_nxt = held_x_r;
    if (step_en) begin
      if (line_end) begin
        if (ok) begin
          held_y_nxt = first_r;
          held_x_nxt = cur_val;
        end
        phase_nxt = PH_WS1;
        cnt_nxt   = '0;
        mag_nxt   = '0;
        neg_nxt   = 1'b0;
        first_nxt = '0;
      end else if (cnt_r != CNT_LAST) begin
        cnt_nxt = cnt_r + 1'b1;
        if (byte_in == CH_NUL) begin
          phase_nxt = ok ? PH_DONE : PH_FAIL;
        end else begin
          case (phase_r)
            PH_WS1, PH_WS2: begin
              if (is_space) begin
                phase_nxt = phase_r;
              end else if (is_sign) begin
                neg_nxt   = (byte_in == CH_MINUS);
                phase_nxt = (phase_r == PH_WS1) ? PH_SGN1 : PH_SGN2;
              end else if (is_digit) begin
                mag_nxt   = mag_add;
                phase_nxt = (phase_r == PH_WS1) ? PH_DIG1 : PH_DIG2;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_SGN1, PH_SGN2: begin
              if (is_digit) begin
                mag_nxt   = mag_add;
                phase_nxt = (phase_r == PH_SGN1) ? PH_DIG1 : PH_DIG2;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_DIG1: begin
              if (is_digit) begin
                mag_nxt = mag_add;
              end else if (byte_in == CH_COMMA) begin
                first_nxt = cur_val;
                mag_nxt   = '0;
                neg_nxt   = 1'b0;
                phase_nxt = PH_WS2;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_DIG2: begin
              if (is_digit) begin
                mag_nxt = mag_add;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            PH_DONE: phase_nxt = PH_DONE;
            default: phase_nxt = PH_FAIL;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WS1;
      cnt_r    <= '0;
      mag_r    <= '0;
      neg_r    <= 1'b0;
      first_r  <= '0;
      held_y_r <= '0;
      held_x_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      mag_r    <= mag_nxt;
      neg_r    <= neg_nxt;
      first_r  <= first_nxt;
      held_y_r <= held_y_nxt;
      held_x_r <= held_x_nxt;
    end
  end

  // Result of the line being closed by this byte; taken only on a newline.
  assign res.ok = ok;
  assign res.y  = held_y_nxt;
  assign res.x  = held_x_nxt;

endmodule

[design/sdlp_out_stage.sv]
// Result register of the parser with its valid flag and stream handshake.
// Depends on sdlp_pkg.
module sdlp_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  sdlp_pkg::res_t d,
  input  logic           take,
  output logic           vld,
  output logic           space,
  output sdlp_pkg::res_t q
);

  logic           vld_r, vld_nxt;
  sdlp_pkg::res_t q_r;

  // The register can be written when empty or when its content leaves now.
  assign space = !vld_r || take;

  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (load) begin
      q_r <= d;
    end
  end

  assign vld = vld_r;
  assign q   = q_r;

endmodule

[design/signed_decimal_pair_line_parser_unit.sv]
// Top level of the signed decimal pair line parser: input byte register,
// parse step and result register. Depends on sdlp_pkg, sdlp_scan, sdlp_out_stage.
//
//   Channel  Direction  tdata (low bit up)             tuser
//   in_      slave      rx_data[7:0]                   -
//   out_     master     coord_y[31:0], coord_x[63:32]  parse_ok
//
// One byte is taken per cycle unless a newline waits for room in the result
// register. An accepted byte sits in the input register, is then applied to
// the parse state, and a newline puts its transaction into the result register,
// which raises out_tvalid. The single parse step on the input register sets the
// rate. While a result waits, bytes other than a newline keep flowing; a second
// newline holds in the input register until the result is taken. rst_n is
// synchronous, active low, and clears all state but the byte and result data.
//
// Each newline-terminated line is read as "y,x": two signed decimal numbers
// with optional leading whitespace and sign, the comma right after the first
// number's digits, anything after the second number's digits ignored. Only the
// first LINE_BYTES-1 bytes of a line count and a zero byte ends the scan.
// Values saturate to the signed 32-bit range, and the coordinates carried out
// are the last ones from a line that parsed successfully.
module signed_decimal_pair_line_parser_unit #(
  parameter int LINE_BYTES = sdlp_pkg::LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] coord_y, [63:32] coord_x
  output logic        out_tuser   // [0] parse_ok
);

  logic                        byte_vld_r, byte_vld_nxt;
  logic [sdlp_pkg::BYTE_W-1:0] byte_r;
  logic                        line_end, out_space, step_en, in_fire;
  sdlp_pkg::res_t              res, res_q;

  // A newline needs room in the result register; other bytes never wait.
  assign step_en   = byte_vld_r && (!line_end || out_space);
  assign in_tready = !byte_vld_r || step_en;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    if (in_fire) begin
      byte_vld_nxt = 1'b1;
    end else if (step_en) begin
      byte_vld_nxt = 1'b0;
    end else begin
      byte_vld_nxt = byte_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
    end
    if (in_fire) begin
      byte_r <= in_tdata;
    end
  end

  sdlp_scan #(
    .LINE_BYTES (LINE_BYTES)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .byte_in  (byte_r),
    .line_end (line_end),
    .res      (res)
  );

  sdlp_out_stage u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (step_en && line_end),
    .d     (res),
    .take  (out_tready),
    .vld   (out_tvalid),
    .space (out_space),
    .q     (res_q)
  );

  assign out_tdata = {res_q.x, res_q.y};
  assign out_tuser = res_q.ok;

endmodule

[sim/signed_decimal_pair_line_parser_unit_tb.sv]
// Self-checking bench for signed_decimal_pair_line_parser_unit: directed and random
// text lines go in one byte per transaction and each finished line is checked
// against a line parser kept in the bench. Depends on sdlp_pkg and the design top.
`timescale 1ns / 100ps

module signed_decimal_pair_line_parser_unit_tb;

  localparam int LINE_LIMIT  = sdlp_pkg::LINE_BYTES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_BYTES  = 120;

  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_VTAB    = 8'd11;
  localparam logic [7:0] CH_FF      = 8'd12;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_COMMA   = 8'd44;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_DIGIT0  = 8'd48;
  localparam logic [7:0] CH_DIGIT9  = 8'd57;
  localparam logic [7:0] CH_TOP     = 8'd255;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [3:0] {
    SCAN_WS1, SCAN_SGN1, SCAN_DIG1, SCAN_WS2, SCAN_SGN2, SCAN_DIG2, SCAN_DONE, SCAN_FAIL
  } scan_phase_t;

  // A pending byte for the sender, or a request to pause until every line is back.
  typedef struct {
    logic [7:0] data;
    bit         drain;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  rx_item_t       rx_queue[$];
  sdlp_pkg::res_t line_results[$];
  logic [7:0]     line_buf[$];

  // Parser state kept by the bench.
  scan_phase_t        phase;
  int unsigned        line_len;
  logic [31:0]        mag_acc;
  bit                 neg;
  logic signed [31:0] first_val;
  logic signed [31:0] held_y;
  logic signed [31:0] held_x;

  int  mismatch_cnt = 0;
  int  results_seen = 0;
  int  cycle_cnt = 0;
  int  tx_gap_left = 0;
  int  rx_gap_left = 0;
  int  long_hold_left = 0;
  bit  long_hold_done = 0;
  bit  draining = 0;
  bit  quiet_tail = 0;

  signed_decimal_pair_line_parser_unit #(
    .LINE_BYTES(LINE_LIMIT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- line parser

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_DIGIT0 && c <= CH_DIGIT9;
  endfunction

  // Value of the number being read, clamped to the signed 32-bit range.
  function automatic logic signed [31:0] clamped_value();
    if (neg) return (mag_acc >= MAG_CAP) ? MAG_CAP : -mag_acc;
    return (mag_acc >= MAG_CAP) ? POS_MAX : mag_acc;
  endfunction

  function automatic void take_digit(logic [7:0] c);
    logic [63:0] wide;
    wide = {32'd0, mag_acc} * 64'd10 + {56'd0, c - CH_DIGIT0};
    mag_acc = (wide > {32'd0, MAG_CAP}) ? MAG_CAP : wide[31:0];
  endfunction

  function automatic void scan_char(logic [7:0] c);
    if (c == CH_NUL) begin
      phase = (phase == SCAN_DIG2 || phase == SCAN_DONE) ? SCAN_DONE : SCAN_FAIL;
      return;
    end
    case (phase)
      SCAN_WS1, SCAN_WS2: begin
        if (is_blank(c)) return;
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
          phase = (phase == SCAN_WS1) ? SCAN_SGN1 : SCAN_SGN2;
        end else if (is_digit(c)) begin
          take_digit(c);
          phase = (phase == SCAN_WS1) ? SCAN_DIG1 : SCAN_DIG2;
        end else begin
          phase = SCAN_FAIL;
        end
      end
      SCAN_SGN1, SCAN_SGN2: begin
        if (is_digit(c)) begin
          take_digit(c);
          phase = (phase == SCAN_SGN1) ? SCAN_DIG1 : SCAN_DIG2;
        end else begin
          phase = SCAN_FAIL;
        end
      end
      SCAN_DIG1: begin
        if (is_digit(c)) begin
          take_digit(c);
        end else if (c == CH_COMMA) begin
          first_val = clamped_value();
          mag_acc = '0;
          neg = 0;
          phase = SCAN_WS2;
        end else begin
          phase = SCAN_FAIL;
        end
      end
      SCAN_DIG2: begin
        // Anything but a digit closes the second number; the rest is ignored.
        if (is_digit(c)) take_digit(c);
        else phase = SCAN_DONE;
      end
      SCAN_DONE: ;
      default: phase = SCAN_FAIL;
    endcase
  endfunction

  // Applies one accepted byte; a newline queues the line's expected result.
  function automatic void apply_rx_byte(logic [7:0] c);
    sdlp_pkg::res_t r;
    if (c == CH_NEWLINE) begin
      r.ok = (phase == SCAN_DIG2 || phase == SCAN_DONE);
      if (r.ok) begin
        held_y = first_val;
        held_x = clamped_value();
      end
      r.y = held_y;
      r.x = held_x;
      line_results.push_back(r);
      phase = SCAN_WS1;
      line_len = 0;
      first_val = '0;
      mag_acc = '0;
      neg = 0;
    end else if (line_len < LINE_LIMIT - 1) begin
      line_len++;
      scan_char(c);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_byte(logic [7:0] b);
    rx_item_t it;
    it.data = b;
    it.drain = 0;
    rx_queue.push_back(it);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic void queue_drain();
    rx_item_t it;
    it.data = '0;
    it.drain = 1;
    rx_queue.push_back(it);
  endfunction

  function automatic void queue_blanks(int n);
    for (int i = 0; i < n; i++) queue_byte(CH_SPACE);
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_NEWLINE) ? CH_TOP : b;
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_VTAB;
      2: return CH_FF;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // Appends one number with optional blanks and sign to the line being built.
  function automatic void build_number();
    string digits;
    int n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) line_buf.push_back(random_blank());
    end
    case ($urandom_range(0, 3))
      0: line_buf.push_back(CH_PLUS);
      1: line_buf.push_back(CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: begin
        // Values right at the edge of the 32-bit range.
        case ($urandom_range(0, 2))
          0: digits = "2147483647";
          1: digits = "2147483648";
          default: digits = "2147483649";
        endcase
        for (int i = 0; i < digits.len(); i++) line_buf.push_back(digits[i]);
      end
      1: begin
        n = $urandom_range(11, 20);
        for (int i = 0; i < n; i++) line_buf.push_back(8'(CH_DIGIT0 + $urandom_range(0, 9)));
      end
      default: begin
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) line_buf.push_back(8'(CH_DIGIT0 + $urandom_range(0, 9)));
      end
    endcase
  endfunction

  function automatic void build_pair();
    int n;
    build_number();
    line_buf.push_back(CH_COMMA);
    build_number();
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) line_buf.push_back(any_but_newline());
    end
  endfunction

  // Builds one random line and queues it; returns the bytes it took.
  function automatic int queue_random_line();
    int kind;
    int n;
    int pos;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 68) begin
      build_pair();
    end else if (kind < 80) begin
      // Well-formed text with one byte replaced.
      build_pair();
      pos = $urandom_range(0, line_buf.size() - 1);
      line_buf[pos] = any_but_newline();
    end else if (kind < 90) begin
      n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) line_buf.push_back(any_but_newline());
    end else if (kind < 96) begin
      // A zero byte somewhere in a well-formed line.
      build_pair();
      pos = $urandom_range(0, line_buf.size());
      line_buf.insert(pos, CH_NUL);
    end else if (kind < 98) begin
      // Long line: the pair lands around the byte where scanning stops.
      n = $urandom_range(LINE_LIMIT - 10, LINE_LIMIT);
      for (int i = 0; i < n; i++) line_buf.push_back(CH_SPACE);
      build_pair();
    end
    foreach (line_buf[i]) queue_byte(line_buf[i]);
    queue_byte(CH_NEWLINE);
    return line_buf.size() + 1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_field(string field, logic signed [31:0] want, logic signed [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("Line result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
  endtask

  // Sender: one transaction per cycle at most, with random gaps and pauses on request.
  always @(posedge clk) begin : drive_input
    rx_item_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) apply_rx_byte(in_tdata);
      quiet_tail <= (rx_queue.size() < TAIL_BYTES);
      if (!(in_tvalid && !in_tready)) begin
        if (draining) begin
          if (line_results.size() == 0) draining = 0;
          in_tvalid <= 1'b0;
        end else if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_tvalid <= 1'b0;
        end else if (rx_queue.size() > 0) begin
          nxt = rx_queue.pop_front();
          if (nxt.drain) begin
            draining = 1;
            in_tvalid <= 1'b0;
          end else begin
            in_tvalid <= 1'b1;
            in_tdata <= nxt.data;
            if (!quiet_tail && $urandom_range(0, 5) == 0) tx_gap_left = $urandom_range(1, 10);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, one long hold-off, always ready near the end.
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left--;
      out_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 20) begin
      long_hold_done = 1;
      long_hold_left = 300;
      out_tready <= 1'b0;
    end else if (quiet_tail) begin
      out_tready <= 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) rx_gap_left = $urandom_range(1, 10);
    end
  end

  always @(posedge clk) begin : watch_output
    sdlp_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (line_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("Unexpected line result: ok %0b y %0d x %0d", out_tuser,
                   $signed(out_tdata[31:0]), $signed(out_tdata[63:32]));
      end else begin
        want = line_results.pop_front();
        if (out_tuser !== want.ok) flag_field("parse_ok", want.ok, out_tuser);
        if (out_tdata[31:0] !== want.y) flag_field("coord_y", want.y, out_tdata[31:0]);
        if (out_tdata[63:32] !== want.x) flag_field("coord_x", want.x, out_tdata[63:32]);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : main_flow
    int random_bytes;
    bit mid_drain_done;
    phase = SCAN_WS1;
    line_len = 0;
    mag_acc = '0;
    neg = 0;
    first_val = '0;
    held_y = '0;
    held_x = '0;

    // Directed lines: range extremes, saturation, blanks and signs, the failing
    // shapes, zero byte before and after the second number, and long lines.
    queue_text("0,0\n");
    queue_text("-2147483648,2147483647\n");
    queue_text("+2147483648,-2147483649\n");
    queue_text("99999999999999999999,-99999999999999999999\n");
    queue_byte(CH_SPACE); queue_byte(CH_TAB); queue_byte(CH_CR);
    queue_byte(CH_VTAB); queue_byte(CH_FF);
    queue_text("12,  +34 rest\n");
    queue_text("\n");
    queue_text("1 ,2\n");
    queue_text("1,\n");
    queue_text("-,5\n");
    queue_text("7,8"); queue_byte(CH_NUL); queue_text("junk"); queue_byte(CH_TOP);
    queue_text("\n");
    queue_text("3,"); queue_byte(CH_NUL); queue_text("4\n");
    queue_byte(CH_TOP); queue_text("\n");
    queue_blanks(LINE_LIMIT - 6);  queue_text("9,1\n");
    queue_blanks(LINE_LIMIT - 4);  queue_text("1,23\n");
    queue_blanks(LINE_LIMIT - 3);  queue_text("1,2\n");
    queue_drain();

    // The directed lines above take a little over 500 bytes.
    random_bytes = 0;
    mid_drain_done = 0;
    while (random_bytes < 320) begin
      random_bytes += queue_random_line();
      if (!mid_drain_done && random_bytes >= 160) begin
        queue_drain();
        mid_drain_done = 1;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_queue.size() != 0 || in_tvalid || draining || line_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
design/sdlp_pkg.sv
design/sdlp_scan.sv
design/sdlp_out_stage.sv
design/signed_decimal_pair_line_parser_unit.sv
sim/signed_decimal_pair_line_parser_unit_tb.sv
